>>> design/lrbm_pkg.sv
// Shared types and codes for the labelled relation bit matrix.
package lrbm_pkg;

  // Item kinds carried by an input transaction.
  localparam logic [2:0] KIND_LOAD_LABEL = 3'd0;
  localparam logic [2:0] KIND_CLEAR      = 3'd1;
  localparam logic [2:0] KIND_ADD_LABEL  = 3'd2;
  localparam logic [2:0] KIND_ADD_INDEX  = 3'd3;
  localparam logic [2:0] KIND_CONTAINS   = 3'd4;
  localparam logic [2:0] KIND_INDEX_OF   = 3'd5;

  // Result status codes.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_RANGE     = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [1:0] STAT_DUPLICATE = 2'd3;

  // Operations handed from the front end to the matrix engine.
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_ADD   = 2'd2;
  localparam logic [1:0] OP_TEST  = 2'd3;

  // Register index of the element count on the configuration port.
  localparam logic REG_ELEM_CNT = 1'b0;

  typedef struct packed {
    logic [2:0]          kind;
    logic [3:0]          src_idx;
    logic [3:0]          tgt_idx;
    logic signed [31:0]  source_label;
    logic signed [31:0]  target_label;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       member;
    logic [3:0] found_index;
    logic [8:0] pair_total;
  } out_item_t;

endpackage

>>> design/lrbm_fifo.sv
// Small register-based first-in first-out queue.
module lrbm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  // Status flags and the head entry.
  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  // Pointer and occupancy updates with wrap at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> design/lrbm_front.sv
// Front end: takes items, owns the label table and resolves labels and ranges.
module lrbm_front #(
  parameter int MAX_ELEMENTS = 16,
  parameter int LABEL_WIDTH  = 32,
  parameter int IDX_W        = 4,
  parameter int CMD_W        = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [4:0]         live_n,
  input  logic               push,
  input  lrbm_pkg::in_item_t in_data,
  output logic               full,
  output logic               cmd_push,
  output logic [CMD_W-1:0]   cmd_data,
  input  logic               cmd_full
);

  typedef struct packed {
    logic [1:0]       op;
    logic [1:0]       status;
    logic [3:0]       found;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } cmd_t;

  lrbm_pkg::in_item_t      item_r;
  logic                    valid_r;
  logic [LABEL_WIDTH-1:0]  label_tbl_r [MAX_ELEMENTS];
  logic [MAX_ELEMENTS-1:0] loaded_r;

  logic [LABEL_WIDTH-1:0]  key_s, key_t;
  logic [MAX_ELEMENTS-1:0] in_use, match_s, match_t, self_s;
  logic                    hit_s, hit_t, dup, si_ok, ti_ok, load_en;
  logic [IDX_W-1:0]        idx_s, idx_t, si_idx, ti_idx;
  cmd_t                    cmd;

  // One item is held at a time; it leaves once the command queue has room.
  assign full     = valid_r;
  assign cmd_push = valid_r && !cmd_full;
  assign cmd_data = cmd;

  // Labels are compared in their low bits only.
  assign key_s  = LABEL_WIDTH'($unsigned(item_r.source_label));
  assign key_t  = LABEL_WIDTH'($unsigned(item_r.target_label));
  assign si_ok  = ({1'b0, item_r.src_idx} < live_n);
  assign ti_ok  = ({1'b0, item_r.tgt_idx} < live_n);
  assign si_idx = IDX_W'(item_r.src_idx);
  assign ti_idx = IDX_W'(item_r.tgt_idx);

  // Parallel match of both labels against every loaded slot in use.
  always_comb begin
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      in_use[i]  = loaded_r[i] && (i < int'(live_n));
      match_s[i] = in_use[i] && (label_tbl_r[i] == key_s);
      match_t[i] = in_use[i] && (label_tbl_r[i] == key_t);
      self_s[i]  = (i == int'(item_r.src_idx));
    end
  end

  // Lowest matching slot wins.
  always_comb begin
    hit_s = 1'b0;
    hit_t = 1'b0;
    idx_s = '0;
    idx_t = '0;
    for (int i = MAX_ELEMENTS - 1; i >= 0; i--) begin
      if (match_s[i]) begin
        hit_s = 1'b1;
        idx_s = IDX_W'(i);
      end
      if (match_t[i]) begin
        hit_t = 1'b1;
        idx_t = IDX_W'(i);
      end
    end
  end

  assign dup = |(match_s & ~self_s);

  // Classification into a matrix operation with any early status.
  always_comb begin
    cmd     = '0;
    load_en = 1'b0;
    unique case (item_r.kind)
      lrbm_pkg::KIND_LOAD_LABEL: begin
        if (!si_ok) begin
          cmd.status = lrbm_pkg::STAT_RANGE;
        end else if (dup) begin
          cmd.status = lrbm_pkg::STAT_DUPLICATE;
        end else begin
          load_en = 1'b1;
        end
      end
      lrbm_pkg::KIND_CLEAR: begin
        cmd.op = lrbm_pkg::OP_CLEAR;
      end
      lrbm_pkg::KIND_ADD_LABEL: begin
        if (hit_s && hit_t) begin
          cmd.op  = lrbm_pkg::OP_ADD;
          cmd.row = idx_s;
          cmd.col = idx_t;
        end else begin
          cmd.status = lrbm_pkg::STAT_NOT_FOUND;
        end
      end
      lrbm_pkg::KIND_ADD_INDEX, lrbm_pkg::KIND_CONTAINS: begin
        if (si_ok && ti_ok) begin
          cmd.op  = (item_r.kind == lrbm_pkg::KIND_ADD_INDEX) ?
                    lrbm_pkg::OP_ADD : lrbm_pkg::OP_TEST;
          cmd.row = si_idx;
          cmd.col = ti_idx;
        end else begin
          cmd.status = lrbm_pkg::STAT_RANGE;
        end
      end
      lrbm_pkg::KIND_INDEX_OF: begin
        if (hit_s) begin
          cmd.found = 4'(idx_s);
        end else begin
          cmd.status = lrbm_pkg::STAT_NOT_FOUND;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // Holding register for the item and the loaded flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      loaded_r <= '0;
    end else begin
      if (push && !full) begin
        valid_r <= 1'b1;
      end else if (cmd_push) begin
        valid_r <= 1'b0;
      end
      if (cmd_push && load_en) begin
        loaded_r[si_idx] <= 1'b1;
      end
    end
  end

  // Payload storage: the item and the label table.
  always_ff @(posedge clk) begin
    if (push && !full) begin
      item_r <= in_data;
    end
    if (cmd_push && load_en) begin
      label_tbl_r[si_idx] <= key_s;
    end
  end

endmodule

>>> design/lrbm_back.sv
// Back end: carries out matrix operations and keeps the pair count.
module lrbm_back #(
  parameter int MAX_ELEMENTS = 16,
  parameter int IDX_W        = 4,
  parameter int CMD_W        = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [CMD_W-1:0]    cmd_data,
  input  logic                cmd_empty,
  output logic                cmd_pop,
  output logic                res_push,
  output lrbm_pkg::out_item_t res_data,
  input  logic                res_full
);

  localparam int PT_W = $clog2(MAX_ELEMENTS * MAX_ELEMENTS + 1);

  typedef struct packed {
    logic [1:0]       op;
    logic [1:0]       status;
    logic [3:0]       found;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } cmd_t;

  cmd_t                    cmd;
  logic [MAX_ELEMENTS-1:0] rows_r [MAX_ELEMENTS];
  logic [MAX_ELEMENTS-1:0] cur_row;
  logic [PT_W-1:0]         counter_r, counter_nxt;
  logic                    fire, bit_set;

  assign cmd      = cmd_t'(cmd_data);
  assign fire     = !cmd_empty && !res_full;
  assign cmd_pop  = fire;
  assign res_push = fire;
  assign cur_row  = rows_r[cmd.row];
  assign bit_set  = cur_row[cmd.col];

  // Pair count after this operation.
  always_comb begin
    unique case (cmd.op)
      lrbm_pkg::OP_CLEAR: counter_nxt = '0;
      lrbm_pkg::OP_ADD:   counter_nxt = bit_set ? counter_r : counter_r + 1'b1;
      default:            counter_nxt = counter_r;
    endcase
  end

  // Result transaction.
  always_comb begin
    res_data.status      = cmd.status;
    res_data.member      = (cmd.op == lrbm_pkg::OP_TEST) && bit_set;
    res_data.found_index = cmd.found;
    res_data.pair_total  = 9'(counter_nxt);
  end

  // Matrix rows and count; reset and clear empty the whole matrix at once.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counter_r <= '0;
      for (int i = 0; i < MAX_ELEMENTS; i++) begin
        rows_r[i] <= '0;
      end
    end else if (fire) begin
      counter_r <= counter_nxt;
      if (cmd.op == lrbm_pkg::OP_CLEAR) begin
        for (int i = 0; i < MAX_ELEMENTS; i++) begin
          rows_r[i] <= '0;
        end
      end else if (cmd.op == lrbm_pkg::OP_ADD) begin
        rows_r[cmd.row][cmd.col] <= 1'b1;
      end
    end
  end

endmodule

>>> design/labelled_relation_bit_matrix.sv
// Top level of the labelled relation bit matrix.
//
// Items enter through a queue-style port: in_data is taken at an edge where
// push is high and full is low. Results leave the same way: the oldest result
// sits on out_data while empty is low and is taken at an edge with pop high.
// Every item gives exactly one result, in order.
// The element count is written over the APB-style port at byte address 0.
// An item is held in the front end, where label matches against all slots
// and range checks are resolved, then goes through a queue to the matrix
// engine, which writes its result to the output queue. full is high while
// the front end holds an item, so it takes no new one until that has left.
// Queues of two entries sit between the front end and the engine and after
// the engine. Reset empties the matrix, the pair count, the loaded flags, the
// element count and both queues at once. While pop stays low, results gather
// in the output queue, then the engine stops, the middle queue fills and
// full stays high; nothing is lost.
module labelled_relation_bit_matrix #(
  parameter int MAX_ELEMENTS = 16,
  parameter int LABEL_WIDTH  = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  lrbm_pkg::in_item_t  in_data,
  output logic                empty,
  input  logic                pop,
  output lrbm_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int IDX_W  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CMD_W  = 8 + 2 * IDX_W;
  localparam int RES_W  = $bits(lrbm_pkg::out_item_t);

  logic [4:0]          elem_cnt_r;
  logic [4:0]          live_n;
  logic                reg_hit;
  logic                cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic [CMD_W-1:0]    cmd_wr, cmd_rd;
  logic                res_push, res_full;
  lrbm_pkg::out_item_t res_data;
  logic [RES_W-1:0]    res_rd;

  // Configuration register.
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == lrbm_pkg::REG_ELEM_CNT);
  assign prdata  = reg_hit ? {27'd0, elem_cnt_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_cnt_r <= '0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      elem_cnt_r <= pwdata[4:0];
    end
  end

  // A count above the table size acts as the table size.
  assign live_n = (int'(elem_cnt_r) > MAX_ELEMENTS) ?
                  5'(MAX_ELEMENTS) : elem_cnt_r;

  lrbm_front #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .LABEL_WIDTH  (LABEL_WIDTH),
    .IDX_W        (IDX_W),
    .CMD_W        (CMD_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .live_n   (live_n),
    .push     (push),
    .in_data  (in_data),
    .full     (full),
    .cmd_push (cmd_push),
    .cmd_data (cmd_wr),
    .cmd_full (cmd_full)
  );

  lrbm_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (2)
  ) u_cmd_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_data (cmd_wr),
    .full    (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_rd),
    .empty   (cmd_empty)
  );

  lrbm_back #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .IDX_W        (IDX_W),
    .CMD_W        (CMD_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_data  (cmd_rd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res_data  (res_data),
    .res_full  (res_full)
  );

  lrbm_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_data),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_rd),
    .empty   (empty)
  );

  assign out_data = lrbm_pkg::out_item_t'(res_rd);

`ifndef NO_ASSERTIONS
  // An accepted item keeps the front end busy for the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full) |=> full)
    else $error("front end free right after accepting a transaction");

  // Membership is only reported for a successful test.
  a_member_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.member) |-> (out_data.status == lrbm_pkg::STAT_OK))
    else $error("member set on a failed transaction");

  // A found index is only reported with an ok status.
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_data.found_index != 4'd0)) |->
      (out_data.status == lrbm_pkg::STAT_OK))
    else $error("found index set on a failed transaction");

  // The pair count never exceeds the size of the matrix.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (int'(out_data.pair_total) <= MAX_ELEMENTS * MAX_ELEMENTS))
    else $error("pair count above matrix size");
`endif

endmodule

>>> verif/tb.sv
// Self-checking testbench for the labelled relation bit matrix.
`timescale 1ns / 1ps

module tb;

  localparam int         SLOTS         = 16;
  localparam int         STALL_LIMIT   = 2000;
  localparam int         DRAIN_CYCLES  = 10;
  localparam logic [2:0] KIND_SPARE_6  = 3'd6;
  localparam logic [2:0] KIND_SPARE_7  = 3'd7;
  localparam logic [2:0] ADDR_ELEM_CNT = 3'(4 * int'(lrbm_pkg::REG_ELEM_CNT));

  logic                clk;
  logic                rst_n;
  logic                push;
  logic                full;
  lrbm_pkg::in_item_t  in_data;
  logic                empty;
  logic                pop;
  lrbm_pkg::out_item_t out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  // Predicted contents of the block.
  logic [31:0]      label_mem [SLOTS];
  logic [SLOTS-1:0] label_valid;
  logic [SLOTS-1:0] pair_mem [SLOTS];
  logic [8:0]       pair_tally;
  logic [4:0]       elem_count;

  lrbm_pkg::out_item_t result_q [$];
  int                  errors = 0;
  int                  idle_cycles = 0;
  bit                  no_idle = 1'b0;

  labelled_relation_bit_matrix dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Number of elements in use; an oversized count saturates at the table size.
  function automatic int live_elems();
    return (elem_count > SLOTS) ? SLOTS : int'(elem_count);
  endfunction

  // Lowest live slot holding the label, if any.
  function automatic bit find_slot(input logic [31:0] lbl, output int slot);
    int n;
    n = live_elems();
    slot = 0;
    for (int i = 0; i < n; i++) begin
      if (label_valid[i] && label_mem[i] == lbl) begin
        slot = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Sets one pair, counting it only when it was clear before.
  function automatic logic [1:0] mark_pair(input int row, input int col);
    int n;
    n = live_elems();
    if (row >= n || col >= n) return lrbm_pkg::STAT_RANGE;
    if (!pair_mem[row][col]) begin
      pair_mem[row][col] = 1'b1;
      pair_tally++;
    end
    return lrbm_pkg::STAT_OK;
  endfunction

  // Applies one input transaction to the predicted state and returns its result.
  function automatic lrbm_pkg::out_item_t predict_relation(input lrbm_pkg::in_item_t it);
    int                  n, a, b;
    bit                  fa, fb;
    lrbm_pkg::out_item_t r;
    n = live_elems();
    r = '0;
    r.status = lrbm_pkg::STAT_OK;
    case (it.kind)
      lrbm_pkg::KIND_LOAD_LABEL: begin
        if (int'(it.src_idx) >= n) begin
          r.status = lrbm_pkg::STAT_RANGE;
        end else begin
          for (int i = 0; i < n; i++)
            if (i != int'(it.src_idx) && label_valid[i] &&
                label_mem[i] == it.source_label)
              r.status = lrbm_pkg::STAT_DUPLICATE;
          if (r.status == lrbm_pkg::STAT_OK) begin
            label_mem[it.src_idx]   = it.source_label;
            label_valid[it.src_idx] = 1'b1;
          end
        end
      end
      lrbm_pkg::KIND_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) pair_mem[i] = '0;
        pair_tally = '0;
      end
      lrbm_pkg::KIND_ADD_LABEL: begin
        fa = find_slot(it.source_label, a);
        fb = find_slot(it.target_label, b);
        if (!fa || !fb) r.status = lrbm_pkg::STAT_NOT_FOUND;
        else r.status = mark_pair(a, b);
      end
      lrbm_pkg::KIND_ADD_INDEX: begin
        r.status = mark_pair(int'(it.src_idx), int'(it.tgt_idx));
      end
      lrbm_pkg::KIND_CONTAINS: begin
        if (int'(it.src_idx) >= n || int'(it.tgt_idx) >= n)
          r.status = lrbm_pkg::STAT_RANGE;
        else
          r.member = pair_mem[it.src_idx][it.tgt_idx];
      end
      lrbm_pkg::KIND_INDEX_OF: begin
        if (find_slot(it.source_label, a)) r.found_index = 4'(a);
        else r.status = lrbm_pkg::STAT_NOT_FOUND;
      end
      default: begin
      end
    endcase
    r.pair_total = pair_tally;
    return r;
  endfunction

  // Compares a result transaction with the oldest prediction.
  task automatic check_result(input lrbm_pkg::out_item_t got);
    lrbm_pkg::out_item_t want;
    if (result_q.size() == 0) begin
      errors++;
      $display("%0t: result with none expected, expected nothing, got %p", $time, got);
      return;
    end
    want = result_q.pop_front();
    if (got.status !== want.status) begin
      errors++;
      $display("%0t: status mismatch, expected %0d, got %0d",
               $time, want.status, got.status);
    end
    if (got.member !== want.member) begin
      errors++;
      $display("%0t: member mismatch, expected %0d, got %0d",
               $time, want.member, got.member);
    end
    if (got.found_index !== want.found_index) begin
      errors++;
      $display("%0t: found_index mismatch, expected %0d, got %0d",
               $time, want.found_index, got.found_index);
    end
    if (got.pair_total !== want.pair_total) begin
      errors++;
      $display("%0t: pair_total mismatch, expected %0d, got %0d",
               $time, want.pair_total, got.pair_total);
    end
  endtask

  // Observes every transaction on the three ports at the clock edge.
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (pop && !empty) check_result(out_data);
      if (push && !full) result_q.push_back(predict_relation(in_data));
      if (psel && penable && pwrite && pready && paddr == ADDR_ELEM_CNT)
        elem_count = pwdata[4:0];
    end
  end

  // Ends the run when nothing has moved for too long.
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (push && !full) || (pop && !empty) || (psel && penable))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles == STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // The receiving side takes results with random stalls.
  initial begin
    int gap;
    pop <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  function automatic lrbm_pkg::in_item_t make_item(input logic [2:0] kind,
                                                   input logic [3:0] si,
                                                   input logic [3:0] ti,
                                                   input logic [31:0] sl,
                                                   input logic [31:0] tl);
    lrbm_pkg::in_item_t it;
    it.kind         = kind;
    it.src_idx      = si;
    it.tgt_idx      = ti;
    it.source_label = sl;
    it.target_label = tl;
    return it;
  endfunction

  // Sends one input transaction after a random gap; push stays high afterwards.
  task automatic send_item(input lrbm_pkg::in_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (full);
  endtask

  // Holds the sender back until every predicted result has come out.
  task automatic drain_results();
    push <= 1'b0;
    do @(posedge clk); while (result_q.size() != 0);
  endtask

  // Writes the element count while the block is idle, then reads it back.
  task automatic write_count(input logic [4:0] value);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_ELEM_CNT;
    pwdata  <= {27'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {27'd0, value}) begin
      errors++;
      $display("%0t: element count readback mismatch, expected %0d, got %0d",
               $time, value, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly a label already in a live slot, otherwise an extreme or random value.
  function automatic logic [31:0] pick_label();
    int n, s;
    n = live_elems();
    if (n > 0 && $urandom_range(0, 3) != 0) begin
      s = $urandom_range(0, n - 1);
      if (label_valid[s]) return label_mem[s];
    end
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [3:0] pick_index(input int n);
    if (n > 0 && $urandom_range(0, 7) != 0) return 4'($urandom_range(0, n - 1));
    return 4'($urandom_range(0, 15));
  endfunction

  // Random transaction weighted towards meaningful table and matrix operations.
  function automatic lrbm_pkg::in_item_t random_item();
    int                 n, w;
    lrbm_pkg::in_item_t it;
    n = live_elems();
    w = $urandom_range(0, 99);
    if (w < 12)      it.kind = lrbm_pkg::KIND_LOAD_LABEL;
    else if (w < 15) it.kind = lrbm_pkg::KIND_CLEAR;
    else if (w < 40) it.kind = lrbm_pkg::KIND_ADD_LABEL;
    else if (w < 60) it.kind = lrbm_pkg::KIND_ADD_INDEX;
    else if (w < 80) it.kind = lrbm_pkg::KIND_CONTAINS;
    else if (w < 94) it.kind = lrbm_pkg::KIND_INDEX_OF;
    else             it.kind = ($urandom_range(0, 1) != 0) ? KIND_SPARE_7 : KIND_SPARE_6;
    it.src_idx      = pick_index(n);
    it.tgt_idx      = pick_index(n);
    it.target_label = pick_label();
    if (it.kind == lrbm_pkg::KIND_LOAD_LABEL && $urandom_range(0, 3) != 0)
      it.source_label = $urandom();
    else
      it.source_label = pick_label();
    return it;
  endfunction

  // With no elements in use every indexed operation is out of range.
  task automatic test_unconfigured();
    send_item(make_item(lrbm_pkg::KIND_LOAD_LABEL, 4'd0, 4'd0, 32'd5, 32'd0));
    send_item(make_item(lrbm_pkg::KIND_ADD_INDEX, 4'd0, 4'd0, 32'd0, 32'd0));
    send_item(make_item(lrbm_pkg::KIND_CONTAINS, 4'd0, 4'd0, 32'd0, 32'd0));
    send_item(make_item(lrbm_pkg::KIND_INDEX_OF, 4'd0, 4'd0, 32'd5, 32'd0));
    send_item(make_item(lrbm_pkg::KIND_ADD_LABEL, 4'd0, 4'd0, 32'd5, 32'd5));
    send_item(make_item(lrbm_pkg::KIND_CLEAR, 4'd15, 4'd15, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF));
  endtask

  // Label loads, duplicates, lookups and pair operations on four elements.
  task automatic test_label_table();
    write_count(5'd4);
    send_item(make_item(lrbm_pkg::KIND_LOAD_LABEL, 4'd0, 4'd0, 32'h8000_0000, 32'd0));
    send_item(make_item(lrbm_pkg::KIND_LOAD_LABEL, 4'd1, 4'd0, 32'h7FFF_FFFF, 32'd0));
    send_item(make_item(lrbm_pkg::KIND_LOAD_LABEL, 4'd2, 4'd0, 32'd0, 32'd0));
    send_item(make_item(lrbm_pkg::KIND_LOAD_LABEL, 4'd3, 4'd0, 32'hFFFF_FFFF, 32'd0));
    // A label held by another slot is refused; a slot may keep its own label.
    send_item(make_item(lrbm_pkg::KIND_LOAD_LABEL, 4'd1, 4'd0, 32'h8000_0000, 32'd0));
    send_item(make_item(lrbm_pkg::KIND_LOAD_LABEL, 4'd0, 4'd0, 32'h8000_0000, 32'd0));
    send_item(make_item(lrbm_pkg::KIND_LOAD_LABEL, 4'd4, 4'd0, 32'd77, 32'd0));
    send_item(make_item(lrbm_pkg::KIND_LOAD_LABEL, 4'd15, 4'd15, 32'h1234_5678, 32'd0));
    send_item(make_item(lrbm_pkg::KIND_INDEX_OF, 4'd0, 4'd0, 32'hFFFF_FFFF, 32'd0));
    send_item(make_item(lrbm_pkg::KIND_INDEX_OF, 4'd0, 4'd0, 32'd12345, 32'd0));
    send_item(make_item(lrbm_pkg::KIND_ADD_LABEL, 4'd0, 4'd0, 32'h8000_0000,
                        32'h7FFF_FFFF));
    send_item(make_item(lrbm_pkg::KIND_ADD_LABEL, 4'd0, 4'd0, 32'h8000_0000,
                        32'h7FFF_FFFF));
    send_item(make_item(lrbm_pkg::KIND_ADD_LABEL, 4'd0, 4'd0, 32'd0, 32'h0000_1234));
    send_item(make_item(lrbm_pkg::KIND_ADD_INDEX, 4'd3, 4'd15, 32'd0, 32'd0));
    send_item(make_item(lrbm_pkg::KIND_ADD_INDEX, 4'd15, 4'd3, 32'd0, 32'd0));
    send_item(make_item(lrbm_pkg::KIND_ADD_INDEX, 4'd2, 4'd3, 32'd0, 32'd0));
    send_item(make_item(lrbm_pkg::KIND_CONTAINS, 4'd0, 4'd1, 32'd0, 32'd0));
    send_item(make_item(lrbm_pkg::KIND_CONTAINS, 4'd1, 4'd0, 32'd0, 32'd0));
    send_item(make_item(lrbm_pkg::KIND_CONTAINS, 4'd15, 4'd0, 32'd0, 32'd0));
    send_item(make_item(KIND_SPARE_6, 4'd15, 4'd15, 32'hFFFF_FFFF, 32'h8000_0000));
    send_item(make_item(KIND_SPARE_7, 4'd0, 4'd0, 32'h7FFF_FFFF, 32'd0));
  endtask

  // A count above the table size behaves as the full table.
  task automatic test_oversized_count();
    write_count(5'd31);
    send_item(make_item(lrbm_pkg::KIND_LOAD_LABEL, 4'd15, 4'd0, 32'h5A5A_A5A5, 32'd0));
    send_item(make_item(lrbm_pkg::KIND_ADD_INDEX, 4'd15, 4'd15, 32'd0, 32'd0));
    send_item(make_item(lrbm_pkg::KIND_ADD_LABEL, 4'd0, 4'd0, 32'h5A5A_A5A5,
                        32'h8000_0000));
    send_item(make_item(lrbm_pkg::KIND_CONTAINS, 4'd15, 4'd15, 32'd0, 32'd0));
    send_item(make_item(lrbm_pkg::KIND_INDEX_OF, 4'd0, 4'd0, 32'h5A5A_A5A5, 32'd0));
    write_count(5'd16);
    send_item(make_item(lrbm_pkg::KIND_INDEX_OF, 4'd0, 4'd0, 32'h5A5A_A5A5, 32'd0));
  endtask

  // Shrinking the count leaves pairs outside the range in the total until cleared.
  task automatic test_stale_pairs();
    write_count(5'd2);
    send_item(make_item(lrbm_pkg::KIND_CONTAINS, 4'd15, 4'd15, 32'd0, 32'd0));
    send_item(make_item(lrbm_pkg::KIND_ADD_INDEX, 4'd1, 4'd1, 32'd0, 32'd0));
    send_item(make_item(lrbm_pkg::KIND_INDEX_OF, 4'd0, 4'd0, 32'h5A5A_A5A5, 32'd0));
    write_count(5'd16);
    send_item(make_item(lrbm_pkg::KIND_CONTAINS, 4'd15, 4'd15, 32'd0, 32'd0));
    send_item(make_item(lrbm_pkg::KIND_CLEAR, 4'd0, 4'd0, 32'd0, 32'd0));
    send_item(make_item(lrbm_pkg::KIND_CONTAINS, 4'd15, 4'd15, 32'd0, 32'd0));
  endtask

  // Every pair of the full table is set, so the total reaches its maximum.
  task automatic test_full_matrix();
    write_count(5'd16);
    no_idle = 1'b1;
    for (int r = 0; r < SLOTS; r++)
      for (int c = 0; c < SLOTS; c++)
        send_item(make_item(lrbm_pkg::KIND_ADD_INDEX, 4'(r), 4'(c), $urandom(),
                            $urandom()));
    send_item(make_item(lrbm_pkg::KIND_ADD_INDEX, 4'd0, 4'd0, 32'd0, 32'd0));
    send_item(make_item(lrbm_pkg::KIND_CONTAINS, 4'd15, 4'd15, 32'd0, 32'd0));
    send_item(make_item(lrbm_pkg::KIND_CLEAR, 4'd0, 4'd0, 32'd0, 32'd0));
    no_idle = 1'b0;
  endtask

  // Loads every live slot, then runs random transactions with bursts and a pause.
  task automatic test_random_phase(input logic [4:0] count, input int items);
    write_count(count);
    no_idle = 1'b0;
    for (int s = 0; s < live_elems(); s++)
      send_item(make_item(lrbm_pkg::KIND_LOAD_LABEL, 4'(s), 4'd0, $urandom(),
                          $urandom()));
    for (int i = 0; i < items; i++) begin
      if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (i == items / 2) drain_results();
      send_item(random_item());
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n   <= 1'b0;
    push    <= 1'b0;
    in_data <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    for (int i = 0; i < SLOTS; i++) begin
      label_mem[i] = '0;
      pair_mem[i]  = '0;
    end
    label_valid = '0;
    pair_tally  = '0;
    elem_count  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_unconfigured();
    test_label_table();
    test_oversized_count();
    test_stale_pairs();
    test_full_matrix();
    test_random_phase(5'd16, 100);
    test_random_phase(5'd1, 100);
    test_random_phase(5'd7, 100);
    test_random_phase(5'd31, 100);
    test_random_phase(5'd0, 60);
    test_random_phase(5'd12, 100);
    test_random_phase(5'd17, 100);
    test_random_phase(5'd3, 100);
    test_random_phase(5'd16, 100);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && result_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
